// ===== sv/kbd_pkg.sv =====
package kbd_pkg;

   typedef enum logic [1:0] {
      OP_SCAN      = 2'd0,
      OP_READ_Q    = 2'd1,
      OP_LOAD      = 2'd2,
      OP_READ_LAST = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_LED   = 3'd0,
      KIND_CHAR  = 3'd1,
      KIND_EMPTY = 3'd2,
      KIND_LAST  = 3'd3,
      KIND_BREAK = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      CLS_SHIFT_DN,
      CLS_SHIFT_UP,
      CLS_CAPS,
      CLS_NUM,
      CLS_CTRL_DN,
      CLS_CTRL_UP,
      CLS_BREAK_KEY,
      CLS_KEY,
      CLS_RELEASE,
      CLS_READ_Q,
      CLS_LOAD,
      CLS_READ_LAST
   } cls_type;

   typedef struct packed {
      cls_type    cls;
      logic [6:0] code;
      logic [7:0] map_index;
      logic [7:0] map_char;
   } req_entry_type;

   localparam logic [7:0] LED_CMD      = 8'hED;
   localparam logic [6:0] SC_BREAK_KEY = 7'h2E;
   localparam logic [6:0] SC_CTRL      = 7'h1D;
   localparam logic [6:0] SC_LSHIFT    = 7'h2A;
   localparam logic [6:0] SC_RSHIFT    = 7'h36;
   localparam logic [6:0] SC_CAPS      = 7'h3A;
   localparam logic [6:0] SC_NUM       = 7'h45;
   localparam int         LED_NUM_BIT  = 1;
   localparam int         LED_CAPS_BIT = 2;

endpackage

// ===== sv/kbd_if.sv =====
interface kbd_req_if;
   logic             valid;
   logic             ready;
   kbd_pkg::op_type  op;
   logic [7:0]       scan_byte;
   logic [7:0]       map_index;
   logic [7:0]       map_char;

   modport source(output valid, op, scan_byte, map_index, map_char, input ready);
   modport sink(input valid, op, scan_byte, map_index, map_char, output ready);
endinterface

interface kbd_rsp_if;
   logic              valid;
   logic              ready;
   kbd_pkg::kind_type kind;
   logic [7:0]        value;
   logic              last;

   modport source(output valid, kind, value, last, input ready);
   modport sink(input valid, kind, value, last, output ready);
endinterface

// ===== sv/kbd_front.sv =====
module kbd_front (
   input  logic                   clock,
   input  logic                   reset,
   kbd_req_if.sink                req_ch,
   output logic                   entry_valid,
   output kbd_pkg::req_entry_type entry,
   input  logic                   entry_pop
);
   import kbd_pkg::*;

   req_entry_type fifo_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   req_entry_type cls_entry;
   logic          push;
   logic          is_shift;

   always_comb begin
      is_shift            = (req_ch.scan_byte[6:0] == SC_LSHIFT) ||
                            (req_ch.scan_byte[6:0] == SC_RSHIFT);
      cls_entry.code      = req_ch.scan_byte[6:0];
      cls_entry.map_index = req_ch.map_index;
      cls_entry.map_char  = req_ch.map_char;
      cls_entry.cls       = CLS_RELEASE;
      case (req_ch.op)
         OP_SCAN: begin
            if (req_ch.scan_byte[7]) begin
               if (is_shift)
                  cls_entry.cls = CLS_SHIFT_UP;
               else if (req_ch.scan_byte[6:0] == SC_CTRL)
                  cls_entry.cls = CLS_CTRL_UP;
               else
                  cls_entry.cls = CLS_RELEASE;
            end else if (is_shift) begin
               cls_entry.cls = CLS_SHIFT_DN;
            end else if (req_ch.scan_byte[6:0] == SC_CAPS) begin
               cls_entry.cls = CLS_CAPS;
            end else if (req_ch.scan_byte[6:0] == SC_NUM) begin
               cls_entry.cls = CLS_NUM;
            end else if (req_ch.scan_byte[6:0] == SC_CTRL) begin
               cls_entry.cls = CLS_CTRL_DN;
            end else if (req_ch.scan_byte[6:0] == SC_BREAK_KEY) begin
               cls_entry.cls = CLS_BREAK_KEY;
            end else begin
               cls_entry.cls = CLS_KEY;
            end
         end
         OP_READ_Q:    cls_entry.cls = CLS_READ_Q;
         OP_LOAD:      cls_entry.cls = CLS_LOAD;
         OP_READ_LAST: cls_entry.cls = CLS_READ_LAST;
         default:      cls_entry.cls = CLS_RELEASE;
      endcase
   end

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign entry_valid  = (count_ff != 2'd0);
   assign entry        = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push      ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = entry_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, entry_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         fifo_ff[wr_ptr_ff] <= cls_entry;
   end

endmodule

// ===== sv/kbd_back.sv =====
module kbd_back #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   entry_valid,
   input  kbd_pkg::req_entry_type entry,
   output logic                   entry_pop,
   kbd_rsp_if.source              rsp_ch
);
   import kbd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_FETCH    = 3'b001,
      ST_EXEC     = 3'b010,
      ST_LED_DATA = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   req_entry_type  cur_ff;
   logic           ctrl_ff, ctrl_in;
   logic           shift_ff, shift_in;
   logic           caps_ff, caps_in;
   logic [2:0]     led_ff, led_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [7:0]     recent_ff, recent_in;
   logic [7:0]     key_rd_ff;
   logic [7:0]     q_rd_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       rsp_kind_ff, rsp_kind_in;
   logic [7:0]     rsp_value_ff, rsp_value_in;
   logic           rsp_last_ff, rsp_last_in;

   logic [7:0]     key_mem [256];
   logic [7:0]     q_mem [QUEUE_DEPTH];

   logic             out_free;
   logic             key_we, q_we;
   logic [7:0]       key_rd_addr;
   logic [PTR_W-1:0] head_next, tail_next;
   logic             q_full, q_empty;

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign entry_pop   = (state_ff == ST_FETCH) && entry_valid;
   assign key_rd_addr = {shift_ff || caps_ff, entry.code};
   assign head_next   = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign tail_next   = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign q_full      = (head_next == tail_ff);
   assign q_empty     = (head_ff == tail_ff);

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.kind  = rsp_kind_ff;
   assign rsp_ch.value = rsp_value_ff;
   assign rsp_ch.last  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      ctrl_in      = ctrl_ff;
      shift_in     = shift_ff;
      caps_in      = caps_ff;
      led_in       = led_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      recent_in    = recent_ff;
      key_we       = 1'b0;
      q_we         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_FETCH: begin
            if (entry_valid)
               state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (cur_ff.cls)
               CLS_SHIFT_DN: begin
                  if (out_free) begin
                     shift_in             = 1'b1;
                     led_in[LED_CAPS_BIT] = 1'b1;
                     rsp_valid_in         = 1'b1;
                     rsp_kind_in          = KIND_LED;
                     rsp_value_in         = LED_CMD;
                     rsp_last_in          = 1'b0;
                     state_in             = ST_LED_DATA;
                  end
               end
               CLS_SHIFT_UP: begin
                  if (caps_ff) begin
                     shift_in = 1'b0;
                     state_in = ST_FETCH;
                  end else if (out_free) begin
                     shift_in             = 1'b0;
                     led_in[LED_CAPS_BIT] = 1'b0;
                     rsp_valid_in         = 1'b1;
                     rsp_kind_in          = KIND_LED;
                     rsp_value_in         = LED_CMD;
                     rsp_last_in          = 1'b0;
                     state_in             = ST_LED_DATA;
                  end
               end
               CLS_CAPS: begin
                  if (out_free) begin
                     caps_in              = !caps_ff;
                     led_in[LED_CAPS_BIT] = !led_ff[LED_CAPS_BIT];
                     rsp_valid_in         = 1'b1;
                     rsp_kind_in          = KIND_LED;
                     rsp_value_in         = LED_CMD;
                     rsp_last_in          = 1'b0;
                     state_in             = ST_LED_DATA;
                  end
               end
               CLS_NUM: begin
                  if (out_free) begin
                     led_in[LED_NUM_BIT] = !led_ff[LED_NUM_BIT];
                     rsp_valid_in        = 1'b1;
                     rsp_kind_in         = KIND_LED;
                     rsp_value_in        = LED_CMD;
                     rsp_last_in         = 1'b0;
                     state_in            = ST_LED_DATA;
                  end
               end
               CLS_CTRL_DN: begin
                  ctrl_in  = 1'b1;
                  state_in = ST_FETCH;
               end
               CLS_CTRL_UP: begin
                  ctrl_in  = 1'b0;
                  state_in = ST_FETCH;
               end
               CLS_BREAK_KEY, CLS_KEY: begin
                  if (ctrl_ff && (cur_ff.cls == CLS_BREAK_KEY)) begin
                     if (out_free) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_BREAK;
                        rsp_value_in = 8'd0;
                        rsp_last_in  = 1'b1;
                        state_in     = ST_FETCH;
                     end
                  end else begin
                     recent_in = key_rd_ff;
                     if (!q_full) begin
                        q_we    = 1'b1;
                        head_in = head_next;
                     end
                     state_in = ST_FETCH;
                  end
               end
               CLS_READ_Q: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (q_empty) begin
                        rsp_kind_in  = KIND_EMPTY;
                        rsp_value_in = 8'd0;
                     end else begin
                        rsp_kind_in  = KIND_CHAR;
                        rsp_value_in = q_rd_ff;
                        tail_in      = tail_next;
                     end
                     state_in = ST_FETCH;
                  end
               end
               CLS_LOAD: begin
                  key_we   = 1'b1;
                  state_in = ST_FETCH;
               end
               CLS_READ_LAST: begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_LAST;
                     rsp_value_in = recent_ff;
                     rsp_last_in  = 1'b1;
                     recent_in    = 8'd0;
                     state_in     = ST_FETCH;
                  end
               end
               default: begin
                  state_in = ST_FETCH;
               end
            endcase
         end
         ST_LED_DATA: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_LED;
               rsp_value_in = {5'd0, led_ff};
               rsp_last_in  = 1'b1;
               state_in     = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FETCH;
         ctrl_ff      <= 1'b0;
         shift_ff     <= 1'b0;
         caps_ff      <= 1'b0;
         led_ff       <= 3'd0;
         head_ff      <= '0;
         tail_ff      <= '0;
         recent_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_ff      <= ctrl_in;
         shift_ff     <= shift_in;
         caps_ff      <= caps_in;
         led_ff       <= led_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         recent_ff    <= recent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (entry_pop)
         cur_ff <= entry;
   end

   // keymap and character ring: one write and one registered read each
   always_ff @(posedge clock) begin
      if (key_we)
         key_mem[cur_ff.map_index] <= cur_ff.map_char;
      if (entry_pop)
         key_rd_ff <= key_mem[key_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_we)
         q_mem[head_ff] <= key_rd_ff;
      if (entry_pop)
         q_rd_ff <= q_mem[tail_ff];
   end

endmodule

// ===== sv/keyboard_scancode_decoder_unit.sv =====
// Set-1 scancode decoder. Requests (scancode, queue read, keymap load,
// read-and-clear of the last character) enter a two-entry request queue and
// are executed one at a time by the back end through a fetch state, which
// issues the keymap and ring-buffer reads, and an execute state; a request
// that sends the two LED bytes also passes an LED-data state. Responses wait
// while the response side holds rsp ready low. The ring buffer holds
// QUEUE_DEPTH-1 characters and drops new ones when full. The keymap has no
// reset; every entry a key press uses must be loaded first.
module keyboard_scancode_decoder_unit #(
   parameter int QUEUE_DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   kbd_req_if.sink    req_ch,
   kbd_rsp_if.source  rsp_ch
);
   import kbd_pkg::*;

   logic          entry_valid;
   logic          entry_pop;
   req_entry_type entry;

   kbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_pop   (entry_pop)
   );

   kbd_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_pop   (entry_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== sv/kbd_checker.sv =====
module kbd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input kbd_pkg::kind_type rsp_kind,
   input logic [7:0]        rsp_value,
   input logic              rsp_last
);
   import kbd_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_value) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_first_is_led_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_LED && rsp_value == LED_CMD)
      else $error("non-final response is not the LED command");

   a_led_data_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
      rsp_valid && rsp_last && rsp_kind == KIND_LED && rsp_value[7:3] == 5'd0)
      else $error("LED data byte did not follow the LED command");

   a_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EMPTY || rsp_kind == KIND_BREAK) |->
      rsp_value == 8'd0 && rsp_last)
      else $error("empty or break response carries data");

endmodule

bind keyboard_scancode_decoder_unit kbd_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.kind),
   .rsp_value (rsp_ch.value),
   .rsp_last  (rsp_ch.last)
);

// ===== bench/keyboard_scancode_decoder_unit_tb.sv =====
`timescale 1ns / 1ps

module keyboard_scancode_decoder_unit_tb;
   import kbd_pkg::*;

   localparam int RING_DEPTH     = 32;
   localparam int IDLE_PCT       = 13;
   localparam int STIM_TARGET    = 1550;
   localparam int DRAIN_CYCLES   = 20;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct {
      op_type     op;
      logic [7:0] scan_byte;
      logic [7:0] map_index;
      logic [7:0] map_char;
      bit         hold;
   } key_request_type;

   typedef struct {
      kind_type   kind;
      logic [7:0] value;
      logic       last;
   } key_response_type;

   logic clock;
   logic reset;

   kbd_req_if req_bus();
   kbd_rsp_if rsp_bus();

   keyboard_scancode_decoder_unit #(.QUEUE_DEPTH(RING_DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   key_request_type  req_backlog[$];
   key_response_type rsp_expected[$];
   key_request_type  req_now;

   // decoder state as predicted
   logic       ctrl_held;
   logic       shift_held;
   logic       caps_on;
   logic [2:0] led_state;
   logic [7:0] ring[RING_DEPTH];
   int         wr_ptr;
   int         rd_ptr;
   logic [7:0] recent;
   logic [7:0] key_map[256];

   // stimulus-side view of the modifiers, to keep key presses on loaded entries
   logic gen_ctrl;
   logic gen_shift;
   logic gen_caps;
   bit   gen_loaded[256];
   bit   hold_pending;
   int   gen_count;

   int fail_count;
   int n_req;
   int n_rsp;
   int n_led;
   int n_break;
   int n_dropped;
   int idle_cycles;
   logic calm;

   assign calm = (n_req >= 600 && n_req < 900);

   function automatic void expect_rsp(kind_type k, logic [7:0] v, logic l);
      key_response_type r;
      r.kind  = k;
      r.value = v;
      r.last  = l;
      rsp_expected.push_back(r);
   endfunction

   function automatic void expect_leds();
      expect_rsp(KIND_LED, LED_CMD, 1'b0);
      expect_rsp(KIND_LED, {5'd0, led_state}, 1'b1);
      n_led++;
   endfunction

   function automatic void predict_request(key_request_type it);
      logic [6:0] code;
      logic [7:0] ch;
      int         next_wr;
      code = it.scan_byte[6:0];
      case (it.op)
         OP_SCAN: begin
            if (it.scan_byte[7]) begin
               if (code == SC_LSHIFT || code == SC_RSHIFT) begin
                  shift_held = 1'b0;
                  if (!caps_on) begin
                     led_state[LED_CAPS_BIT] = 1'b0;
                     expect_leds();
                  end
               end else if (code == SC_CTRL) begin
                  ctrl_held = 1'b0;
               end
            end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
               shift_held = 1'b1;
               led_state[LED_CAPS_BIT] = 1'b1;
               expect_leds();
            end else if (code == SC_CAPS) begin
               caps_on = !caps_on;
               led_state[LED_CAPS_BIT] = !led_state[LED_CAPS_BIT];
               expect_leds();
            end else if (code == SC_NUM) begin
               led_state[LED_NUM_BIT] = !led_state[LED_NUM_BIT];
               expect_leds();
            end else if (code == SC_CTRL) begin
               ctrl_held = 1'b1;
            end else if (code == SC_BREAK_KEY && ctrl_held) begin
               expect_rsp(KIND_BREAK, 8'd0, 1'b1);
               n_break++;
            end else begin
               ch = key_map[{shift_held || caps_on, code}];
               recent = ch;
               next_wr = (wr_ptr + 1) % RING_DEPTH;
               if (next_wr != rd_ptr) begin
                  ring[wr_ptr] = ch;
                  wr_ptr = next_wr;
               end else begin
                  n_dropped++;
               end
            end
         end
         OP_READ_Q: begin
            if (wr_ptr == rd_ptr) begin
               expect_rsp(KIND_EMPTY, 8'd0, 1'b1);
            end else begin
               expect_rsp(KIND_CHAR, ring[rd_ptr], 1'b1);
               rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            end
         end
         OP_LOAD: begin
            key_map[it.map_index] = it.map_char;
         end
         default: begin
            expect_rsp(KIND_LAST, recent, 1'b1);
            recent = 8'd0;
         end
      endcase
   endfunction

   function automatic void push_req(op_type op, logic [7:0] sc, logic [7:0] idx,
                                    logic [7:0] ch);
      key_request_type it;
      it.op        = op;
      it.scan_byte = sc;
      it.map_index = idx;
      it.map_char  = ch;
      it.hold      = hold_pending;
      hold_pending = 1'b0;
      req_backlog.push_back(it);
      gen_count++;
   endfunction

   function automatic void load_key(logic [7:0] idx, logic [7:0] ch);
      gen_loaded[idx] = 1'b1;
      push_req(OP_LOAD, 8'($urandom_range(255)), idx, ch);
   endfunction

   function automatic void read_req(op_type op);
      push_req(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
   endfunction

   // any key press that consults the keymap gets its entry loaded first
   function automatic void send_scan(logic [7:0] sc);
      logic [6:0] code;
      logic [7:0] slot;
      code = sc[6:0];
      if (sc[7]) begin
         if (code == SC_LSHIFT || code == SC_RSHIFT) gen_shift = 1'b0;
         else if (code == SC_CTRL) gen_ctrl = 1'b0;
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
         gen_shift = 1'b1;
      end else if (code == SC_CAPS) begin
         gen_caps = !gen_caps;
      end else if (code == SC_CTRL) begin
         gen_ctrl = 1'b1;
      end else if (code != SC_NUM && !(code == SC_BREAK_KEY && gen_ctrl)) begin
         slot = {gen_shift || gen_caps, code};
         if (!gen_loaded[slot]) load_key(slot, 8'($urandom_range(255)));
      end
      push_req(OP_SCAN, sc, 8'($urandom_range(255)), 8'($urandom_range(255)));
   endfunction

   function automatic logic [6:0] pick_shift();
      return $urandom_range(1) ? SC_LSHIFT : SC_RSHIFT;
   endfunction

   function automatic void type_keys(int n);
      logic [6:0] code;
      int         r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 12) begin
            send_scan({gen_shift, pick_shift()});
         end else if (r < 17) begin
            send_scan({1'b0, SC_CAPS});
         end else begin
            code = 7'($urandom_range(127));
            send_scan({1'b0, code});
            if ($urandom_range(2) == 0) send_scan({1'b1, code});
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_request(req_now);
            n_req++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
                !(req_backlog[0].hold && rsp_expected.size() != 0)) begin
               req_now = req_backlog.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.op        <= req_now.op;
               req_bus.scan_byte <= req_now.scan_byte;
               req_bus.map_index <= req_now.map_index;
               req_bus.map_char  <= req_now.map_char;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      key_response_type exp_rsp;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_bus.valid && rsp_bus.ready) begin
            n_rsp++;
            if (rsp_expected.size() == 0) begin
               $error("unexpected response: kind %0d value 0x%02h last %0b",
                      rsp_bus.kind, rsp_bus.value, rsp_bus.last);
               fail_count++;
            end else begin
               exp_rsp = rsp_expected.pop_front();
               if (rsp_bus.kind !== exp_rsp.kind) begin
                  $error("kind: expected %0d, got %0d", exp_rsp.kind, rsp_bus.kind);
                  fail_count++;
               end
               if (rsp_bus.value !== exp_rsp.value) begin
                  $error("value: expected 0x%02h, got 0x%02h", exp_rsp.value, rsp_bus.value);
                  fail_count++;
               end
               if (rsp_bus.last !== exp_rsp.last) begin
                  $error("last: expected %0b, got %0b", exp_rsp.last, rsp_bus.last);
                  fail_count++;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      int n;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_SCAN;
      req_bus.scan_byte = 8'd0;
      req_bus.map_index = 8'd0;
      req_bus.map_char  = 8'd0;
      rsp_bus.ready     = 1'b0;
      ctrl_held = 1'b0;
      shift_held = 1'b0;
      caps_on = 1'b0;
      led_state = 3'd0;
      wr_ptr = 0;
      rd_ptr = 0;
      recent = 8'd0;
      gen_ctrl = 1'b0;
      gen_shift = 1'b0;
      gen_caps = 1'b0;
      hold_pending = 1'b0;
      gen_count = 0;
      fail_count = 0;
      n_req = 0;
      n_rsp = 0;
      n_led = 0;
      n_break = 0;
      n_dropped = 0;
      idle_cycles = 0;

      // directed
      read_req(OP_READ_Q);
      read_req(OP_READ_LAST);
      load_key(8'h00, 8'h00);
      load_key(8'hFF, 8'hFF);
      load_key(8'h1E, 8'h61);
      load_key(8'h9E, 8'h41);
      send_scan(8'h1E);
      send_scan(8'h9E);
      send_scan({1'b0, SC_LSHIFT});
      send_scan(8'h1E);
      send_scan({1'b1, SC_LSHIFT});
      send_scan({1'b0, SC_CAPS});
      send_scan(8'h1E);
      send_scan({1'b0, SC_RSHIFT});
      send_scan({1'b1, SC_RSHIFT});
      send_scan({1'b0, SC_CAPS});
      send_scan({1'b0, SC_NUM});
      send_scan({1'b0, SC_NUM});
      send_scan({1'b0, SC_CTRL});
      send_scan({1'b0, SC_BREAK_KEY});
      send_scan({1'b1, SC_CTRL});
      send_scan({1'b0, SC_BREAK_KEY});
      send_scan(8'hFF);
      send_scan(8'h00);
      read_req(OP_READ_Q);
      read_req(OP_READ_Q);
      read_req(OP_READ_LAST);
      read_req(OP_READ_LAST);

      // random
      hold_pending = 1'b1;
      while (gen_count < STIM_TARGET) begin
         if (gen_count > STIM_TARGET / 2 && gen_count < STIM_TARGET / 2 + 10)
            hold_pending = 1'b1;
         r = $urandom_range(99);
         if (r < 30) begin
            type_keys($urandom_range(1, 8));
         end else if (r < 45) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
               read_req($urandom_range(3) == 0 ? OP_READ_LAST : OP_READ_Q);
         end else if (r < 55) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               load_key(8'($urandom_range(255)), 8'($urandom_range(255)));
         end else if (r < 65) begin
            send_scan({1'b0, SC_CTRL});
            if ($urandom_range(1)) type_keys($urandom_range(1, 3));
            send_scan({1'b0, SC_BREAK_KEY});
            if ($urandom_range(4) != 0) send_scan({1'b1, SC_CTRL});
         end else if (r < 73) begin
            send_scan({1'b0, $urandom_range(1) ? SC_NUM : SC_CAPS});
         end else if (r < 78) begin
            // type a burst that can overrun the character queue, then issue up to 36 queue reads
            type_keys($urandom_range(35, 45));
            n = $urandom_range(0, 36);
            for (int i = 0; i < n; i++) read_req(OP_READ_Q);
         end else begin
            case ($urandom_range(3))
               0: send_scan(8'($urandom_range(255)));
               1: read_req(OP_READ_Q);
               2: load_key(8'($urandom_range(255)), 8'($urandom_range(255)));
               default: read_req(OP_READ_LAST);
            endcase
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_bus.valid || rsp_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (rsp_expected.size() != 0) begin
         $error("%0d expected responses never arrived", rsp_expected.size());
         fail_count++;
      end
      $display("Sent %0d requests (keymap loads, scancodes, queue and last-char reads),",
               n_req);
      $display("checked %0d responses: %0d LED updates, %0d breaks, %0d chars dropped on full",
               n_rsp, n_led, n_break, n_dropped);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/kbd_pkg.sv
sv/kbd_if.sv
sv/kbd_front.sv
sv/kbd_back.sv
sv/keyboard_scancode_decoder_unit.sv
sv/kbd_checker.sv
bench/keyboard_scancode_decoder_unit_tb.sv
